// File: rtl/tmr_pkg.sv
// shared types and codes for the timer table
`timescale 1ns / 1ps
`default_nettype none
package tmr_pkg;

  typedef enum logic [2:0] {
    KIND_TICK   = 3'd0,
    KIND_ATTACH = 3'd1,
    KIND_DETACH = 3'd2,
    KIND_SET    = 3'd3,
    KIND_POLL   = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_OP,
    ST_SWEEP
  } state_e;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  slot;
    logic [31:0] value;
  } tmr_in_t;

  typedef struct packed {
    logic        fired;
    logic [31:0] now_time;
  } tmr_out_t;

  typedef struct packed {
    kind_e kind;
    logic  wrapped;
  } tmr_ctrl_t;

endpackage
`default_nettype wire

// File: rtl/tmr_slot_mem.sv
// slot state memory with per-entry valid bits and registered read
`timescale 1ns / 1ps
`default_nettype none
module tmr_slot_mem #(
  parameter int SLOTS = 16,
  parameter int EW    = 67,
  parameter int SW    = 4
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [SW-1:0] raddr_i,
  output logic      [EW-1:0] rdata_o,
  input  wire logic          we_i,
  input  wire logic [SW-1:0] waddr_i,
  input  wire logic [EW-1:0] wdata_i
);
  import tmr_pkg::*;

  logic [EW-1:0] mem_q [SLOTS];
  logic [SLOTS-1:0] vld_q;
  logic [EW-1:0] rd_q;
  logic rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rd_q <= mem_q[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      rd_vld_q <= vld_q[raddr_i];
    end
  end

  // an entry never written since reset reads as cleared
  assign rdata_o = rd_vld_q ? rd_q : '0;

endmodule
`default_nettype wire

// File: rtl/tmr_slot_upd.sv
// read-modify-write update of one slot entry
`timescale 1ns / 1ps
`default_nettype none
module tmr_slot_upd #(
  parameter int TW = 32
) (
  input  wire tmr_pkg::tmr_ctrl_t ctrl_i,
  input  wire logic [TW-1:0]      now_i,
  input  wire logic [TW-1:0]      value_i,
  input  wire logic [2*TW+2:0]    entry_i,
  output logic      [2*TW+2:0]    entry_o,
  output logic                    fired_o
);
  import tmr_pkg::*;

  logic          att, expf, wp;
  logic [TW-1:0] dl, iv;
  logic          att_n, exp_n, wp_n;
  logic [TW-1:0] dl_n, iv_n;
  logic [TW-1:0] rs_iv, rs_dl;
  logic          wp_t;

  assign att = entry_i[2*TW+2];
  assign expf = entry_i[2*TW+1];
  assign wp  = entry_i[2*TW];
  assign dl  = entry_i[2*TW-1:TW];
  assign iv  = entry_i[TW-1:0];

  // restart uses the new interval on a set
  assign rs_iv = (ctrl_i.kind == KIND_SET) ? value_i : iv;
  assign rs_dl = now_i + rs_iv;

  always_comb begin
    att_n   = att;
    exp_n   = expf;
    wp_n    = wp;
    dl_n    = dl;
    iv_n    = iv;
    fired_o = 1'b0;
    wp_t    = wp;
    case (ctrl_i.kind)
      KIND_TICK: begin
        if (att && !expf) begin
          if (ctrl_i.wrapped && !wp) begin
            exp_n = 1'b1;
          end else begin
            if (ctrl_i.wrapped) begin
              wp_t = 1'b0;
            end
            wp_n = wp_t;
            if (!wp_t && now_i >= dl) begin
              exp_n = 1'b1;
            end
          end
        end
      end
      KIND_ATTACH: begin
        att_n = 1'b1;
        exp_n = 1'b1;
        wp_n  = 1'b0;
        dl_n  = '0;
        iv_n  = '0;
      end
      KIND_DETACH: begin
        att_n = 1'b0;
        exp_n = 1'b0;
        wp_n  = 1'b0;
        dl_n  = '0;
        iv_n  = '0;
      end
      KIND_SET: begin
        if (att) begin
          iv_n  = value_i;
          dl_n  = rs_dl;
          exp_n = 1'b0;
          wp_n  = !(rs_dl > now_i);
        end
      end
      KIND_POLL: begin
        if (att && expf) begin
          dl_n    = rs_dl;
          exp_n   = 1'b0;
          wp_n    = !(rs_dl > now_i);
          fired_o = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign entry_o = {att_n, exp_n, wp_n, dl_n, iv_n};

endmodule
`default_nettype wire

// File: rtl/timer_table_with_wrap.sv
// top level of the timer table with a shared wrapping time counter
`timescale 1ns / 1ps
`default_nettype none
// Timer table: SLOTS timer slots share one TIME_WIDTH-bit wrapping counter.
// Slot state lives in a single-port-write memory with a registered read. A tick
// with a nonzero step walks every slot through a read-modify-write pipeline,
// staying busy until the last slot is written back. Attach, detach, set and
// poll touch one entry and are busy while it is written back. A zero-step
// tick, an unused kind or a one-entry command with an out-of-range slot
// answers on the next cycle without going busy. Each result is shown for one
// cycle on valid_o and cannot be held off by the receiver.
module timer_table_with_wrap #(
  parameter int SLOTS      = 16,
  parameter int TIME_WIDTH = 32
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire tmr_pkg::tmr_in_t in_i,
  output logic                  valid_o,
  output tmr_pkg::tmr_out_t     out_o
);
  import tmr_pkg::*;

  localparam int TW = TIME_WIDTH;
  localparam int EW = 2 * TW + 3;
  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  state_e        state_q, state_d;
  tmr_in_t       cmd_q, cmd_d;
  logic [TW-1:0] time_q, time_d;
  logic          wrap_q, wrap_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          valid_q, valid_d;
  tmr_out_t      out_q, out_d;

  logic [SW-1:0] raddr, waddr;
  logic          we;
  logic [EW-1:0] rdata, wdata;
  tmr_ctrl_t     ctrl;
  logic          upd_fired;
  logic [TW-1:0] in_val, cmd_val;
  logic [63:0]   in_v64, cmd_v64, time64;
  logic          slot_ok;

  assign in_v64  = 64'(in_i.value);
  assign in_val  = in_v64[TW-1:0];
  assign cmd_v64 = 64'(cmd_q.value);
  assign cmd_val = cmd_v64[TW-1:0];
  assign time64  = 64'(time_d);
  assign slot_ok = 9'(in_i.slot) < 9'(SLOTS);

  tmr_slot_mem #(
    .SLOTS (SLOTS),
    .EW    (EW),
    .SW    (SW)
  ) u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .raddr_i (raddr),
    .rdata_o (rdata),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata)
  );

  tmr_slot_upd #(
    .TW (TW)
  ) u_upd (
    .ctrl_i  (ctrl),
    .now_i   (time_q),
    .value_i (cmd_val),
    .entry_i (rdata),
    .entry_o (wdata),
    .fired_o (upd_fired)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      time_q  <= '0;
      wrap_q  <= 1'b0;
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      time_q  <= time_d;
      wrap_q  <= wrap_d;
      cnt_q   <= cnt_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    out_q <= out_d;
  end

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    time_d       = time_q;
    wrap_d       = wrap_q;
    cnt_d        = cnt_q;
    valid_d      = 1'b0;
    out_d        = out_q;
    raddr        = SW'(in_i.slot);
    waddr        = SW'(cmd_q.slot);
    we           = 1'b0;
    ctrl.kind    = kind_e'(cmd_q.kind);
    ctrl.wrapped = wrap_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_d = in_i;
          if (in_i.kind == KIND_TICK && in_val != '0) begin
            time_d  = time_q + in_val;
            wrap_d  = !(time_d > time_q);
            cnt_d   = '0;
            state_d = ST_SWEEP;
          end else if (in_i.kind inside {KIND_ATTACH, KIND_DETACH, KIND_SET, KIND_POLL} &&
                       slot_ok) begin
            state_d = ST_OP;
          end else begin
            valid_d        = 1'b1;
            out_d.fired    = 1'b0;
            out_d.now_time = time64[31:0];
          end
        end
      end
      ST_OP: begin
        we             = 1'b1;
        valid_d        = 1'b1;
        out_d.fired    = upd_fired;
        out_d.now_time = time64[31:0];
        state_d        = ST_IDLE;
      end
      ST_SWEEP: begin
        // read slot cnt while writing back slot cnt-1
        ctrl.kind = KIND_TICK;
        raddr     = cnt_q[SW-1:0];
        waddr     = SW'(cnt_q - 1'b1);
        we        = (cnt_q != '0);
        if (cnt_q == CW'(SLOTS)) begin
          valid_d        = 1'b1;
          out_d.fired    = 1'b0;
          out_d.now_time = time64[31:0];
          state_d        = ST_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy    = (state_q != ST_IDLE);
  assign valid_o = valid_q;
  assign out_o   = out_q;

endmodule
`default_nettype wire
